FILE: rtl/kvt_pkg.sv
// Package for the key/value table: command and status codes, default sizes.
// No dependencies; used by key_value_table_core.
package kvt_pkg;

  // Default sizes
  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned DefKeyWidth   = 32;
  localparam int unsigned DefValueWidth = 32;

  // Command codes
  localparam logic [1:0] CmdSet    = 2'd0;
  localparam logic [1:0] CmdGet    = 2'd1;
  localparam logic [1:0] CmdDelete = 2'd2;
  localparam logic [1:0] CmdClear  = 2'd3;

  // Status codes
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

endpackage

FILE: rtl/key_value_table_core.sv
// Key/value table: associative store of up to TABLE_DEPTH pairs in one
// synchronous memory. Depends on kvt_pkg.
//
// Usage: present command_i, lookup_key_i and write_value_i with start high;
// the command is taken at a clock edge where start is high and busy low.
// busy stays high until the result goes out. Each command gives exactly one
// result, shown for one cycle with done_o high: status_o, read_value_o and
// entry_count_o (pairs held after the command). A new command may be started
// in the same cycle as the result strobe.
// Timing: the table memory is read one entry per cycle through a registered
// read port, so the lookup is a linear scan of the occupied entries.
//   clear: result 1 cycle after the transfer.
//   empty table: result straight from the scan state, with no reads.
//   match at entry i: result after entry i is compared; a delete that is not
//   of the last entry adds S_MOVE to move the last pair into the freed slot.
//   no match: result after the last occupied entry is compared.
// Delete fills the hole with the last pair, so entries stay packed in
// 0 .. count-1; only the count matters to the results, not the order.
// Reset: the count is cleared at once; the memory contents are not touched
// and need no clearing pass, as only entries below the count are ever read.
// The receiver cannot stall: a result is dropped if not taken in its cycle.
module key_value_table_core #(
  parameter int unsigned TABLE_DEPTH = kvt_pkg::DefTableDepth,
  parameter int unsigned KEY_WIDTH   = kvt_pkg::DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = kvt_pkg::DefValueWidth,
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             command_i,
  input  logic [KEY_WIDTH-1:0]   lookup_key_i,
  input  logic [VALUE_WIDTH-1:0] write_value_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [VALUE_WIDTH-1:0] read_value_o,
  output logic [CntW-1:0]        entry_count_o
);

  localparam int unsigned EntW = KEY_WIDTH + VALUE_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  // Table memory, entries packed as {key, value}
  logic [EntW-1:0] mem_q [TABLE_DEPTH];
  logic [EntW-1:0] rdata_q;

  logic            mem_rd_en;
  logic [IdxW-1:0] mem_rd_addr;
  logic            mem_wr_en;
  logic [IdxW-1:0] mem_wr_addr;
  logic [EntW-1:0] mem_wr_data;

  logic [1:0]             state_q, state_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]        cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic                   issued_last_q, issued_last_d;
  logic                   data_vld_q, data_vld_d;
  logic                   done_q, done_d;
  logic [1:0]             status_q, status_d;
  logic [VALUE_WIDTH-1:0] rdval_q, rdval_d;

  logic                   accept;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [IdxW-1:0]        last_idx;
  logic                   match;
  logic                   at_last;

  assign accept   = start && !busy;
  assign rd_key   = rdata_q[EntW-1:VALUE_WIDTH];
  assign rd_val   = rdata_q[VALUE_WIDTH-1:0];
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign match    = data_vld_q && (rd_key == key_q);
  assign at_last  = data_vld_q && (cmp_idx_q == last_idx);

  // Sequencer: clear at once, or scan, then insert, update, read or delete
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    val_d         = val_q;
    count_d       = count_q;
    rd_idx_d      = rd_idx_q;
    cmp_idx_d     = cmp_idx_q;
    hit_idx_d     = hit_idx_q;
    issued_last_d = issued_last_q;
    data_vld_d    = 1'b0;
    done_d        = 1'b0;
    status_d      = status_q;
    rdval_d       = rdval_q;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = rd_idx_q;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cmp_idx_q;
    mem_wr_data   = {key_q, val_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = command_i;
          key_d = lookup_key_i;
          val_d = write_value_i;
          if (command_i == kvt_pkg::CmdClear) begin
            count_d  = '0;
            status_d = kvt_pkg::StDone;
            rdval_d  = '0;
            done_d   = 1'b1;
          end else begin
            rd_idx_d      = '0;
            issued_last_d = 1'b0;
            state_d       = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (count_q == '0 || (at_last && !match)) begin
          // No matching key
          rdval_d = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == kvt_pkg::CmdSet) begin
            if (count_q < CntW'(TABLE_DEPTH)) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = IdxW'(count_q);
              count_d     = count_q + CntW'(1);
              status_d    = kvt_pkg::StDone;
            end else begin
              status_d = kvt_pkg::StFull;
            end
          end else begin
            status_d = kvt_pkg::StNotFound;
          end
        end else if (match) begin
          status_d = kvt_pkg::StDone;
          rdval_d  = '0;
          case (cmd_q)
            kvt_pkg::CmdSet: begin
              mem_wr_en = 1'b1;
              done_d    = 1'b1;
              state_d   = S_IDLE;
            end
            kvt_pkg::CmdGet: begin
              rdval_d = rd_val;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
            default: begin
              // Delete: fill the hole with the last pair unless it is the last
              if (cmp_idx_q == last_idx) begin
                count_d = count_q - CntW'(1);
                done_d  = 1'b1;
                state_d = S_IDLE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = last_idx;
                hit_idx_d   = cmp_idx_q;
                state_d     = S_MOVE;
              end
            end
          endcase
        end else if (!issued_last_q) begin
          // Advance the scan: issue the next read
          mem_rd_en     = 1'b1;
          mem_rd_addr   = rd_idx_q;
          cmp_idx_d     = rd_idx_q;
          data_vld_d    = 1'b1;
          issued_last_d = (rd_idx_q == last_idx);
          rd_idx_d      = rd_idx_q + IdxW'(1);
        end
      end

      S_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = hit_idx_q;
        mem_wr_data = rdata_q;
        count_d     = count_q - CntW'(1);
        status_d    = kvt_pkg::StDone;
        rdval_d     = '0;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      issued_last_q <= 1'b0;
      data_vld_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      issued_last_q <= issued_last_d;
      data_vld_q    <= data_vld_d;
      done_q        <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    val_q     <= val_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    status_q  <= status_d;
    rdval_q   <= rdval_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem_q[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      rdata_q <= mem_q[mem_rd_addr];
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rdval_q;
  assign entry_count_o = count_q;

endmodule
